[hdl/ett_pkg.sv]
// Package with the shared types, codes and constants of the entity track table.
package ett_pkg;

    localparam logic [31:0] HASH_MUL = 32'd2654435761;
    localparam logic [12:0] BLEND_ONE = 13'd4096;
    localparam logic [47:0] JUMP_RESET = 48'd1474560000;
    localparam logic [7:0] STALE_RESET = 8'd4;

    localparam logic [2:0] ST_CONT = 3'd0;
    localparam logic [2:0] ST_FRESH = 3'd1;
    localparam logic [2:0] ST_DROP = 3'd2;
    localparam logic [2:0] ST_HIT = 3'd3;
    localparam logic [2:0] ST_MISS = 3'd4;

    localparam logic REG_MAX_JUMP = 1'b0;
    localparam logic REG_STALE = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_PREVIEW = 1'b1;

    typedef struct packed {
        logic        operation;
        logic        new_tick;
        logic [31:0] object_key;
        logic [31:0] object_type;
        logic [31:0] object_variant;
        logic signed [23:0] sample_x;
        logic signed [23:0] sample_y;
        logic [12:0] blend;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic signed [23:0] blended_x;
        logic signed [23:0] blended_y;
    } t_out_word;

    // Classified command handed from the front end to the table engine.
    typedef struct packed {
        logic        operation;
        logic [31:0] tick;
        logic [31:0] key;
        logic [31:0] hash;
        logic [31:0] fp_mul;
        logic [31:0] variant;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [12:0] blend;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_FP, S_RD, S_WAIT, S_CHK, S_DX, S_SQ, S_SUM, S_CMP,
        S_WR, S_LX, S_LADD, S_OUT
    } t_eng_state;

endpackage

[hdl/ett_front.sv]
// Front end: tick stamp and key hash, with the fingerprint operands, queued toward the engine.
module ett_front
    import ett_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_word i_word,
    output logic     o_full,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_take
);
    logic [31:0] r_tick;
    logic [31:0] n_tick;
    logic        r_valid;
    t_cmd        r_cmd;
    logic        accept;

    assign o_full = r_valid;
    assign accept = i_push && !r_valid;
    assign n_tick = r_tick + {31'd0, i_word.new_tick};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_tick  <= n_tick;
                r_valid <= 1'b1;
            end else if (i_cmd_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.operation <= i_word.operation;
            r_cmd.tick      <= n_tick;
            r_cmd.key       <= i_word.object_key;
            r_cmd.hash      <= {4'd0, i_word.object_key[31:4]} * HASH_MUL;
            r_cmd.fp_mul    <= i_word.object_type;
            r_cmd.variant   <= i_word.object_variant;
            r_cmd.px        <= i_word.sample_x;
            r_cmd.py        <= i_word.sample_y;
            r_cmd.blend     <= (i_word.blend > BLEND_ONE) ? BLEND_ONE : i_word.blend;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd = r_cmd;
endmodule

[hdl/ett_engine.sv]
// Table engine: key store clear after reset, probe walk over the slot memory, continuity check, update and blend.
module ett_engine
    import ett_pkg::*;
#(
    parameter int SLOTS = 4096,
    parameter int PROBE_LIMIT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_take,
    input  logic [47:0] i_max_jump_sq,
    input  logic [7:0]  i_stale_ticks,
    output logic        o_res_valid,
    output t_out_word   o_res,
    input  logic        i_res_pop,
    output logic        o_clearing
);
    localparam int AW = $clog2(SLOTS);
    localparam int PW = $clog2(PROBE_LIMIT + 1);
    localparam logic [AW-1:0] IDX_MASK = AW'(SLOTS - 1);
    localparam int DW = 32 + 32 + 48 + 48;

    logic [31:0] r_key_mem [SLOTS];
    logic [DW-1:0] r_dat_mem [SLOTS];

    t_eng_state r_state, n_state;
    t_cmd       r_cmd;
    logic [AW-1:0] r_idx;
    logic [PW-1:0] r_probe;
    logic [31:0]   r_fp;
    logic [31:0]   r_rd_key;
    logic [DW-1:0] r_rd_dat;
    logic          r_fresh;
    logic [2:0]    r_status;
    logic signed [24:0] r_dx, r_dy;
    logic [49:0]   r_sqx, r_sqy;
    logic [50:0]   r_d2;
    logic signed [38:0] r_px, r_py;
    logic signed [23:0] r_bx, r_by;
    logic          r_out_valid;
    t_out_word     r_out;
    logic          r_clear;
    logic [AW:0]   r_clr_cnt;

    logic [31:0] rd_fp, rd_stamp;
    logic signed [23:0] rd_px, rd_py, rd_cx, rd_cy;
    logic key_hit, reclaim, probe_end;
    logic key_we, dat_we;
    logic [31:0] key_wd;
    logic out_load;

    assign {rd_fp, rd_stamp, rd_px, rd_py, rd_cx, rd_cy} = r_rd_dat;
    assign key_hit = (r_rd_key == r_cmd.key);
    assign reclaim = (r_rd_key == 32'd0) ||
                     ((r_cmd.tick - rd_stamp) > {24'd0, i_stale_ticks});
    assign probe_end = (r_probe == PW'(PROBE_LIMIT - 1));

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[r_clear ? r_clr_cnt[AW-1:0] : r_idx] <= key_wd;
        end
        r_rd_key <= r_key_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (dat_we) begin
            r_dat_mem[r_idx] <= {r_fp, r_cmd.tick,
                                 r_fresh ? r_cmd.px : rd_cx,
                                 r_fresh ? r_cmd.py : rd_cy,
                                 r_cmd.px, r_cmd.py};
        end
        r_rd_dat <= r_dat_mem[r_idx];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!r_clear && i_cmd_valid) n_state = S_FP;
            S_FP:   n_state = S_RD;
            S_RD:   n_state = S_WAIT;
            S_WAIT: n_state = S_CHK;
            S_CHK: begin
                if (r_cmd.key == 32'd0) n_state = S_OUT;
                else if (key_hit || reclaim) begin
                    if (r_cmd.operation == OP_SAMPLE) n_state = S_DX;
                    else if (key_hit && rd_stamp == r_cmd.tick && rd_fp == r_fp)
                        n_state = S_LX;
                    else n_state = S_OUT;
                end else if (probe_end) n_state = S_OUT;
                else n_state = S_RD;
            end
            S_DX:   n_state = S_SQ;
            S_SQ:   n_state = S_SUM;
            S_SUM:  n_state = S_CMP;
            S_CMP:  n_state = S_WR;
            S_WR:   n_state = S_OUT;
            S_LX:   n_state = S_LADD;
            S_LADD: n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_take = (r_state == S_IDLE) && !r_clear && i_cmd_valid;
        key_we = r_clear ||
                 ((r_state == S_CHK) && (r_cmd.key != 32'd0) && !key_hit && reclaim &&
                  (r_cmd.operation == OP_SAMPLE));
        key_wd = r_clear ? 32'd0 : r_cmd.key;
        dat_we = (r_state == S_WR);
        // The finished result moves out once the output register is free or being popped.
        out_load = (r_state == S_OUT) && (!r_out_valid || i_res_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_clear     <= 1'b1;
            r_clr_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_clear) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == (AW+1)'(SLOTS - 1)) r_clear <= 1'b0;
            end
            if (out_load) r_out_valid <= 1'b1;
            else if (i_res_pop) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cmd   <= i_cmd;
                r_probe <= '0;
                r_idx   <= i_cmd.hash[AW-1:0] & IDX_MASK;
                r_status <= (i_cmd.operation == OP_SAMPLE) ? ST_DROP : ST_MISS;
                r_bx <= '0;
                r_by <= '0;
            end
            S_FP: r_fp <= (r_cmd.fp_mul * HASH_MUL) ^ r_cmd.variant;
            S_CHK: begin
                if (!(key_hit || reclaim)) begin
                    r_idx   <= (r_idx + 1'b1) & IDX_MASK;
                    r_probe <= r_probe + 1'b1;
                end
                // A reclaimed slot holds no history worth keeping.
                r_fresh <= !key_hit || rd_stamp != (r_cmd.tick - 32'd1) || rd_fp != r_fp;
            end
            S_DX: begin
                r_dx <= 25'(r_cmd.px) - 25'(rd_cx);
                r_dy <= 25'(r_cmd.py) - 25'(rd_cy);
            end
            S_SQ: begin
                r_sqx <= 50'(r_dx) * 50'(r_dx);
                r_sqy <= 50'(r_dy) * 50'(r_dy);
            end
            S_SUM: r_d2 <= {1'b0, r_sqx} + {1'b0, r_sqy};
            S_CMP: begin
                if (r_d2 > {3'd0, i_max_jump_sq}) r_fresh <= 1'b1;
            end
            S_WR: r_status <= r_fresh ? ST_FRESH : ST_CONT;
            S_LX: begin
                r_px <= $signed({26'd0, r_cmd.blend}) * (25'(rd_cx) - 25'(rd_px));
                r_py <= $signed({26'd0, r_cmd.blend}) * (25'(rd_cy) - 25'(rd_py));
            end
            S_LADD: begin
                r_status <= ST_HIT;
                r_bx <= 24'(rd_px + 24'((r_px + 39'sd2048) >>> 12));
                r_by <= 24'(rd_py + 24'((r_py + 39'sd2048) >>> 12));
            end
            S_OUT: begin
                if (out_load) begin
                    r_out.status    <= r_status;
                    r_out.blended_x <= r_bx;
                    r_out.blended_y <= r_by;
                end
            end
            default: ;
        endcase
    end

    assign o_res_valid = r_out_valid;
    assign o_res = r_out;
    assign o_clearing = r_clear;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid) else $error("result lost");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> !r_clear) else $error("take while busy");
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_probe < PW'(PROBE_LIMIT))) else $error("probe overrun");
endmodule

[hdl/entity_track_table_unit.sv]
// Top level of the entity track table: config registers, front end and table engine.
//
// Channel   Direction  Handshake                 Word
// input     in         i_push / o_full           t_in_word
// result    out        o_empty / i_pop           t_out_word
// config    in         i_cfg_we                  index + 48-bit data
//
// A sample or a preview probes up to PROBE_LIMIT slots; each probe reads the
// slot memory, waits for its registered read and checks the slot. A sample
// then computes the jump, compares it and writes the slot; a preview that hits blends.
// After reset the key store is swept clear, one slot per cycle, and while it
// is cleared no word is taken. One word waits in the front queue while the
// engine works. A finished result waits in the output register until popped;
// the engine goes on with the next word and holds that result until the
// register is free.
module entity_track_table_unit
    import ett_pkg::*;
#(
    parameter int SLOTS = 4096,
    parameter int PROBE_LIMIT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_in_word    i_word,
    output logic        o_full,
    output logic        o_empty,
    input  logic        i_pop,
    output t_out_word   o_word,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    logic [47:0] r_max_jump_sq;
    logic [7:0]  r_stale_ticks;
    logic        cmd_valid, cmd_take, res_valid, clearing, front_full;
    t_cmd        cmd;

    // Register writes land directly; the user must issue them only while idle, the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_jump_sq <= JUMP_RESET;
            r_stale_ticks <= STALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAX_JUMP: r_max_jump_sq <= i_cfg_data;
                REG_STALE:    r_stale_ticks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input is held off while the key store is being cleared.
    assign o_full = front_full || clearing;

    ett_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push && !clearing),
        .i_word     (i_word),
        .o_full     (front_full),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_take (cmd_take)
    );

    ett_engine #(.SLOTS(SLOTS), .PROBE_LIMIT(PROBE_LIMIT)) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_take   (cmd_take),
        .i_max_jump_sq(r_max_jump_sq),
        .i_stale_ticks(r_stale_ticks),
        .o_res_valid  (res_valid),
        .o_res        (o_word),
        .i_res_pop    (i_pop),
        .o_clearing   (clearing)
    );

    assign o_empty = !res_valid;

    a_full_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> o_full) else $error("accepting during clear");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_pop && !o_empty) |=> (!o_empty && $stable(o_word))) else $error("result changed");
    a_take_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid) else $error("take without command");
endmodule
